### design/fbr_pkg.sv
// shared constants and types for the feedback frame receiver
`timescale 1ns / 1ps
package fbr_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 16;
  localparam int FRAME_BYTES = 18;
  localparam int CHECK_WORDS = 8;
  localparam int OUT_WORDS   = 7;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int PAYLOAD_W   = OUT_WORDS * WORD_W;

  localparam logic [WORD_W-1:0] START_WORD_RESET = 16'hABCD;
  localparam logic [POS_W-1:0]  POS_IDLE  = POS_W'(0);
  localparam logic [POS_W-1:0]  POS_FIRST = POS_W'(2);
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic                 valid;
    logic [PAYLOAD_W-1:0] payload;
  } fbr_result_t;

endpackage

### design/fbr_frame_unit.sv
// frame assembly, start detection and xor check for one byte per cycle while byte_en is high
`timescale 1ns / 1ps
module fbr_frame_unit
  import fbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [WORD_W-1:0] start_word,
  output fbr_result_t       result
);

  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] store_r [FRAME_BYTES];

  logic              start_hit;
  logic              frame_open;
  logic              complete;
  logic [WORD_W-1:0] words [CHECK_WORDS+1];
  logic [WORD_W-1:0] check;

  assign start_hit  = ({rx_byte, prev_r} == start_word);
  assign frame_open = (pos_r >= POS_FIRST) && (pos_r <= POS_LAST);
  assign complete   = !start_hit && (pos_r == POS_LAST);

  always_comb begin
    for (int k = 0; k < CHECK_WORDS; k++) begin
      words[k] = {store_r[2*k+1], store_r[2*k]};
    end
    words[CHECK_WORDS] = {rx_byte, store_r[FRAME_BYTES-2]};
    check = '0;
    for (int k = 0; k < CHECK_WORDS; k++) begin
      check = check ^ words[k];
    end
  end

  always_comb begin
    result.valid = byte_en && complete && (words[0] == start_word)
                   && (check == words[CHECK_WORDS]);
    for (int k = 0; k < OUT_WORDS; k++) begin
      result.payload[k*WORD_W +: WORD_W] = words[k+1];
    end
  end

  always_comb begin
    prev_nxt = prev_r;
    pos_nxt  = pos_r;
    if (byte_en) begin
      prev_nxt = rx_byte;
      if (start_hit) begin
        pos_nxt = POS_FIRST;
      end else if (complete) begin
        pos_nxt = POS_IDLE;
      end else if (frame_open) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      pos_r  <= POS_IDLE;
    end else begin
      prev_r <= prev_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      if (start_hit) begin
        store_r[0] <= prev_r;
        store_r[1] <= rx_byte;
      end else if (frame_open) begin
        store_r[pos_r] <= rx_byte;
      end
    end
  end

endmodule

### design/feedback_frame_receiver_unit.sv
// top level of the feedback frame receiver with output register and skid stage
`timescale 1ns / 1ps
// Takes one received byte per cycle on the in_ stream and emits one word of
// seven 16-bit fields on the out_ stream for every 18-byte frame that opens
// with start_word (low byte first) and whose ninth word equals the xor of the
// first eight. The result is registered in the output register, or in the skid
// register on a stall; bad frames produce nothing. An output register plus one
// skid register sit on the result side, so in_tready stays high unless both
// are held by a stalled consumer. start_word resets to 0xABCD; the user must
// write it through the cfg_ channel while the block is idle (not enforced).
module feedback_frame_receiver_unit
  import fbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // rx_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // command_one, command_two, right_speed, left_speed, battery_voltage,
  // board_temperature, led_word
  output logic [PAYLOAD_W-1:0] out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [WORD_W-1:0]    cfg_data    // start_word
);

  logic [WORD_W-1:0]    start_word_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [PAYLOAD_W-1:0] out_data_r, out_data_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic [PAYLOAD_W-1:0] skid_data_r, skid_data_nxt;
  logic                 in_accept;
  fbr_result_t          result;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !skid_valid_r;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  fbr_frame_unit u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (in_accept),
    .rx_byte    (in_tdata),
    .start_word (start_word_r),
    .result     (result)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = result.valid;
        out_data_nxt  = result.payload;
      end
    end else if (result.valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_word_r <= START_WORD_RESET;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_word_r <= cfg_data;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

### design/fbr_checker.sv
// port-level checks for the feedback frame receiver and their bind
`timescale 1ns / 1ps
module fbr_checker
  import fbr_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [PAYLOAD_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

endmodule

bind feedback_frame_receiver_unit fbr_checker u_fbr_checker (.*);

### dv/tb_feedback_frame_receiver_unit.sv
// self-checking testbench for the feedback frame receiver top level
`timescale 1ns / 1ps
module tb_feedback_frame_receiver_unit;
  import fbr_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // rx_byte
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // command_one, command_two, right_speed, left_speed, battery_voltage,
  // board_temperature, led_word
  logic [PAYLOAD_W-1:0] out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WORD_W-1:0]    cfg_data = '0;   // start_word

  feedback_frame_receiver_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver model state
  logic [WORD_W-1:0] rx_start_word = START_WORD_RESET;
  logic [7:0]        prev_rx = '0;
  int unsigned       frame_pos = 0;
  logic [7:0]        frame_buf [FRAME_BYTES];

  logic [7:0]           rx_bytes_q [$];
  logic [PAYLOAD_W-1:0] pending_feedback [$];
  int                   bytes_queued = 0;
  int                   mismatch_count = 0;
  bit                   in_gaps_on = 1'b0;
  bit                   out_gaps_on = 1'b0;
  int                   hold_req_count = 0;

  string field_name [OUT_WORDS] = '{"command_one", "command_two", "right_speed",
                                    "left_speed", "battery_voltage",
                                    "board_temperature", "led_word"};

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // returns 1 when the byte completes a good frame, with its seven payload words
  function automatic bit absorb_byte(input logic [7:0] rx,
                                     output logic [PAYLOAD_W-1:0] fields);
    logic [WORD_W-1:0] xor_sum;
    bit                good;
    good = 1'b0;
    fields = '0;
    if ({rx, prev_rx} == rx_start_word) begin
      frame_buf[0] = prev_rx;
      frame_buf[1] = rx;
      frame_pos = 2;
    end else if (frame_pos >= 2 && frame_pos < FRAME_BYTES) begin
      frame_buf[frame_pos] = rx;
      frame_pos++;
    end
    if (frame_pos == FRAME_BYTES) begin
      xor_sum = '0;
      for (int k = 0; k < CHECK_WORDS; k++) xor_sum ^= {frame_buf[2*k+1], frame_buf[2*k]};
      if ({frame_buf[1], frame_buf[0]} == rx_start_word &&
          xor_sum == {frame_buf[2*CHECK_WORDS+1], frame_buf[2*CHECK_WORDS]}) begin
        for (int k = 0; k < OUT_WORDS; k++)
          fields[k*WORD_W +: WORD_W] = {frame_buf[2*k+3], frame_buf[2*k+2]};
        good = 1'b1;
      end
      frame_pos = 0;
    end
    prev_rx = rx;
    return good;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WORD_W-1:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    logic [PAYLOAD_W-1:0] p;
    for (int k = 0; k < OUT_WORDS; k++) p[k*WORD_W +: WORD_W] = rand_field();
    return p;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [WORD_W-1:0] sw, input logic [PAYLOAD_W-1:0] pay,
                             input bit spoil);
    logic [WORD_W-1:0] chk;
    chk = sw;
    for (int k = 0; k < OUT_WORDS; k++) chk ^= pay[k*WORD_W +: WORD_W];
    if (spoil) chk ^= 16'(1 << $urandom_range(0, 15));
    push_byte(sw[7:0]);
    push_byte(sw[15:8]);
    for (int k = 0; k < OUT_WORDS; k++) begin
      push_byte(pay[k*WORD_W +: 8]);
      push_byte(pay[k*WORD_W+8 +: 8]);
    end
    push_byte(chk[7:0]);
    push_byte(chk[15:8]);
  endtask

  // start word followed by a cut-short body
  task automatic queue_partial(input int n);
    push_byte(rx_start_word[7:0]);
    push_byte(rx_start_word[15:8]);
    repeat (n) push_byte(8'($urandom));
  endtask

  task automatic queue_traffic(input int n_bytes);
    int first;
    int pick;
    first = bytes_queued;
    while (bytes_queued - first < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) queue_frame(rx_start_word, rand_payload(), 1'b0);
      else if (pick < 78) queue_frame(rx_start_word, rand_payload(), 1'b1);
      else if (pick < 88) repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      else queue_partial($urandom_range(0, 15));
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (rx_bytes_q.size() != 0 || in_tvalid || pending_feedback.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_word(input logic [WORD_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    rx_start_word = value;
  endtask

  task automatic compare_feedback(input logic [PAYLOAD_W-1:0] got);
    logic [PAYLOAD_W-1:0] want;
    if (pending_feedback.size() == 0) begin
      flag_mismatch($sformatf("unexpected result word %h", got));
      return;
    end
    want = pending_feedback.pop_front();
    for (int k = 0; k < OUT_WORDS; k++)
      if (got[k*WORD_W +: WORD_W] !== want[k*WORD_W +: WORD_W])
        flag_mismatch($sformatf("%s got %h want %h", field_name[k],
                                got[k*WORD_W +: WORD_W], want[k*WORD_W +: WORD_W]));
  endtask

  // byte driver, which also feeds accepted bytes to the receiver model
  always @(posedge clk) begin : drive_bytes
    logic [PAYLOAD_W-1:0] fields;
    int                   in_gap;
    if (rst_n && in_tvalid && in_tready) begin
      if (absorb_byte(in_tdata, fields)) pending_feedback.push_back(fields);
    end
    if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_bytes_q.pop_front();
        if (in_gaps_on) in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with its own backpressure
  always @(posedge clk) begin : watch_results
    int out_hold;
    int hold_seen;
    if (rst_n && out_tvalid && out_tready) compare_feedback(out_tdata);
    if (hold_seen != hold_req_count) begin
      hold_seen = hold_req_count;
      out_hold  = LONG_HOLD;
    end
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (out_gaps_on) out_hold = pick_gap();
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] phase_word [6];
    int                waited;
    phase_word = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'($urandom), 16'($urandom),
                   START_WORD_RESET};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // directed frames on the reset start word
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    queue_frame(START_WORD_RESET, '0, 1'b0);
    queue_frame(START_WORD_RESET, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h8000,
                                   16'h7FFF, 16'hFFFF}, 1'b0);
    queue_partial(5);
    queue_frame(START_WORD_RESET, rand_payload(), 1'b0);
    queue_frame(START_WORD_RESET, rand_payload(), 1'b1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hCD);
    push_byte(8'h55);
    queue_frame(START_WORD_RESET, {7{16'hFFFF}}, 1'b0);
    // start word moves while a frame is half received
    queue_partial(8);
    wait_idle();
    write_start_word(16'h1234);
    repeat (8) push_byte(8'($urandom));
    wait_idle();

    // long consumer stall with a steady stream of good frames
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    hold_req_count <= hold_req_count + 1;
    repeat (12) queue_frame(rx_start_word, rand_payload(), 1'b0);
    wait_idle();

    foreach (phase_word[i]) begin
      write_start_word(phase_word[i]);
      in_gaps_on  = (i != 2);
      out_gaps_on = (i != 2) && (i != 4);
      queue_traffic(180);
      wait_idle();
    end

    waited = 0;
    while ((rx_bytes_q.size() != 0 || in_tvalid || pending_feedback.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_feedback.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_feedback.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
